// File: src/random_permutation_drawer_assert.svh
// Assertion macros for the permutation drawer checks.
// Both sample on clk and are disabled while rst_n is low.
`ifndef RANDOM_PERMUTATION_DRAWER_ASSERT_SVH
`define RANDOM_PERMUTATION_DRAWER_ASSERT_SVH

// Same-cycle implication.
`define RPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rpd_pkg.sv
`default_nettype none

package rpd_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 8;
    localparam int GROUP     = 32;
    localparam int MOD_CNT_W = $clog2(WORD_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RST_SIZE  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] RST_COUNT = CFG_W'(1024);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TREE,
        ST_LOAD
    } rpd_state_t;

    // command broadcast to every list cell
    typedef struct packed {
        logic shift;    // close the gap at pos
        logic restore;  // reload identity
    } rpd_cell_op_t;

endpackage

`default_nettype wire

// File: src/rpd_channels.sv
`default_nettype none

interface rpd_in_if import rpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface rpd_out_if #(
    parameter int VAL_W = 10
) ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] drawn_value;
    logic             last_draw;

    modport source (output valid, output drawn_value, output last_draw, input ready);
    modport sink   (input valid, input drawn_value, input last_draw, output ready);
endinterface

interface rpd_cfg_if import rpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// File: src/random_permutation_drawer.sv
// Flow: an accepted word runs the 32-step remainder loop, then the three-level
//   select tree; the list compaction happens in the selection cycle. The result
//   waits for a free slot on rsp, and no new word is taken before it is loaded.
// Reset (rst_n, async low): list back to identity, draw count zero,
//   size and count registers 1024, no result pending. No clearing pass.
`default_nettype none

module random_permutation_drawer import rpd_pkg::*; #(
    parameter int MAX_SIZE = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rpd_in_if.sink     req,
    rpd_out_if.source  rsp,
    rpd_cfg_if.sink    cfg
);

    localparam int VAL_W      = $clog2(MAX_SIZE);
    localparam int SIZE_CAP_I = (MAX_SIZE > (2**CFG_W - 1)) ? (2**CFG_W - 1) : MAX_SIZE;
    localparam logic [CFG_W-1:0] SIZE_CAP = CFG_W'(SIZE_CAP_I);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    rpd_state_t       state_reg;
    rpd_state_t       state_next;
    logic [CFG_W-1:0] size_reg;
    logic [CFG_W-1:0] count_reg;
    logic [CFG_W-1:0] draws_done_reg;
    logic [CFG_W-1:0] draws_done_next;
    logic             last_pend_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_last_reg;

    // ---------------------------------------------------------------
    // Datapath nets
    // ---------------------------------------------------------------
    logic             req_fire;
    logic             cfg_hit;
    logic [CFG_W-1:0] s_eff;
    logic [CFG_W-1:0] c_sat;
    logic [CFG_W-1:0] c_eff;
    logic [CFG_W-1:0] left;
    logic [CFG_W-1:0] done_inc;
    logic             is_last;
    logic             sel;
    logic             out_free;

    logic             mod_start;
    logic             mod_done;
    logic [CFG_W-1:0] pos;

    rpd_cell_op_t     cell_op;
    logic             tree_cap;
    logic             tree_valid;
    logic [VAL_W-1:0] tree_value;
    logic             out_load;

    logic [VAL_W-1:0] cell_val [MAX_SIZE];
    logic [VAL_W-1:0] hit_val  [MAX_SIZE];

    assign req_fire = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    // Writes to indexes past the register list are dropped entirely.
    assign cfg_hit  = cfg.valid && ((cfg.idx == REG_SIZE) || (cfg.idx == REG_COUNT));

    // Effective size: saturate at MAX_SIZE, zero means one.
    always_comb
    begin
        if (size_reg == '0)
        begin
            s_eff = CFG_W'(1);
        end
        else if (size_reg > SIZE_CAP)
        begin
            s_eff = SIZE_CAP;
        end
        else
        begin
            s_eff = size_reg;
        end
    end

    // Effective count: saturate at size, zero means one.
    assign c_sat = (count_reg > s_eff) ? s_eff : count_reg;
    assign c_eff = (c_sat == '0) ? CFG_W'(1) : c_sat;

    // Values still in the list; never zero since draws_done < count <= size.
    assign left     = s_eff - draws_done_reg;
    assign done_inc = draws_done_reg + CFG_W'(1);
    assign is_last  = (done_inc >= c_eff);

    // Selection cycle: remainder is ready, cells close the gap (or restore identity after the final draw).
    assign sel      = (state_reg == ST_DIV) && mod_done;
    assign out_free = !out_valid_reg || rsp.ready;

    // ---------------------------------------------------------------
    // Remainder unit: random_word mod left
    // ---------------------------------------------------------------
    rpd_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.random_word),
        .divisor   (left),
        .done      (mod_done),
        .remainder (pos)
    );

    // ---------------------------------------------------------------
    // Cell chain: cell k holds list entry k and pulls from cell k+1
    // ---------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < MAX_SIZE; k++)
        begin : g_cell
            logic [VAL_W-1:0] right_val;
            if (k == MAX_SIZE - 1)
            begin : g_tail
                // entry past the end is never read again, hold own value
                assign right_val = cell_val[k];
            end
            else
            begin : g_body
                assign right_val = cell_val[k+1];
            end

            rpd_cell #(
                .IDX   (k),
                .VAL_W (VAL_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .pos       (pos),
                .right_val (right_val),
                .val       (cell_val[k]),
                .hit_val   (hit_val[k])
            );
        end
    endgenerate

    // Gathers the one nonzero-masked entry; captured in the selection
    // cycle from the values before the shift.
    rpd_collect #(
        .N     (MAX_SIZE),
        .VAL_W (VAL_W)
    ) u_collect (
        .clk     (clk),
        .rst_n   (rst_n),
        .cap     (tree_cap),
        .in_vals (hit_val),
        .value   (tree_value),
        .valid   (tree_valid)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_TREE;
                end
            end
            ST_TREE:
            begin
                if (tree_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // wait here while the previous result word is unread
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        req.ready       = 1'b0;
        mod_start       = 1'b0;
        tree_cap        = 1'b0;
        out_load        = 1'b0;
        cell_op.shift   = 1'b0;
        cell_op.restore = cfg_hit;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                mod_start = req.valid;
            end
            ST_DIV:
            begin
                if (sel)
                begin
                    tree_cap = 1'b1;
                    // after the final draw the list goes straight to identity
                    cell_op.restore = is_last;
                    cell_op.shift   = !is_last;
                end
            end
            ST_TREE:
            begin
            end
            ST_LOAD:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        draws_done_next = draws_done_reg;
        if (cfg_hit)
        begin
            draws_done_next = '0;
        end
        else if (sel)
        begin
            draws_done_next = is_last ? '0 : done_inc;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= RST_SIZE;
            count_reg      <= RST_COUNT;
            draws_done_reg <= '0;
            last_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            draws_done_reg <= draws_done_next;
            if (cfg.valid && (cfg.idx == REG_SIZE))
            begin
                size_reg <= cfg.data;
            end
            if (cfg.valid && (cfg.idx == REG_COUNT))
            begin
                count_reg <= cfg.data;
            end
            if (sel)
            begin
                last_pend_reg <= is_last;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= tree_value;
            out_last_reg  <= last_pend_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.drawn_value = out_value_reg;
    assign rsp.last_draw   = out_last_reg;

endmodule

`default_nettype wire

// File: src/rpd_cell.sv
`default_nettype none

module rpd_cell import rpd_pkg::*; #(
    parameter int IDX   = 0,
    parameter int VAL_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rpd_cell_op_t     op,
    input  wire logic [CFG_W-1:0] pos,
    input  wire logic [VAL_W-1:0] right_val,
    output logic      [VAL_W-1:0] val,
    output logic      [VAL_W-1:0] hit_val
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic             hit;
    logic             at_or_above;

    assign hit         = (int'(pos) == IDX);
    assign at_or_above = (int'(pos) <= IDX);

    always_comb
    begin
        val_next = val_reg;
        if (op.restore)
        begin
            val_next = VAL_W'(IDX);
        end
        else if (op.shift && at_or_above)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= VAL_W'(IDX);
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val     = val_reg;
    assign hit_val = hit ? val_reg : '0;

endmodule

`default_nettype wire

// File: src/rpd_mod_unit.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module rpd_mod_unit import rpd_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [CFG_W-1:0]  divisor,
    output logic                   done,
    output logic      [CFG_W-1:0]  remainder
);

    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    dvd_next;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     rem_next;
    logic [CFG_W-1:0]     dsr_reg;
    logic [CFG_W-1:0]     dsr_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CFG_W:0]       trial;
    logic                 last_step;

    assign trial     = {rem_reg, dvd_reg[WORD_W-1]};
    assign last_step = busy_reg && (cnt_reg == MOD_CNT_W'(WORD_W - 1));

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = last_step;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CFG_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[CFG_W-1:0];
            end
            cnt_next = cnt_reg + MOD_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: src/rpd_collect.sv
`default_nettype none

// Three-level registered OR tree gathering the single hit value.
module rpd_collect import rpd_pkg::*; #(
    parameter int N     = 1024,
    parameter int VAL_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cap,
    input  wire logic [VAL_W-1:0] in_vals [N],
    output logic      [VAL_W-1:0] value,
    output logic                  valid
);

    localparam int L1 = (N + GROUP - 1) / GROUP;
    localparam int L2 = (L1 + GROUP - 1) / GROUP;
    localparam int L3 = (L2 + GROUP - 1) / GROUP;

    logic [VAL_W-1:0] p0 [L1*GROUP];
    logic [VAL_W-1:0] p1 [L2*GROUP];
    logic [VAL_W-1:0] p2 [L3*GROUP];
    logic [VAL_W-1:0] lvl1_reg [L1];
    logic [VAL_W-1:0] lvl2_reg [L2];
    logic [VAL_W-1:0] lvl3_reg [L3];
    logic [2:0]       v_reg;
    logic [2:0]       v_next;

    genvar i;
    generate
        for (i = 0; i < L1*GROUP; i++)
        begin : g_p0
            if (i < N)
            begin : g_in
                assign p0[i] = in_vals[i];
            end
            else
            begin : g_pad
                assign p0[i] = '0;
            end
        end

        for (i = 0; i < L2*GROUP; i++)
        begin : g_p1
            if (i < L1)
            begin : g_in
                assign p1[i] = lvl1_reg[i];
            end
            else
            begin : g_pad
                assign p1[i] = '0;
            end
        end

        for (i = 0; i < L3*GROUP; i++)
        begin : g_p2
            if (i < L2)
            begin : g_in
                assign p2[i] = lvl2_reg[i];
            end
            else
            begin : g_pad
                assign p2[i] = '0;
            end
        end

        for (i = 0; i < L1; i++)
        begin : g_l1
            logic [VAL_W-1:0] acc;
            always_comb
            begin
                acc = '0;
                for (int j = 0; j < GROUP; j++)
                begin
                    acc = acc | p0[i*GROUP + j];
                end
            end
            always_ff @(posedge clk)
            begin
                if (cap)
                begin
                    lvl1_reg[i] <= acc;
                end
            end
        end

        for (i = 0; i < L2; i++)
        begin : g_l2
            logic [VAL_W-1:0] acc;
            always_comb
            begin
                acc = '0;
                for (int j = 0; j < GROUP; j++)
                begin
                    acc = acc | p1[i*GROUP + j];
                end
            end
            always_ff @(posedge clk)
            begin
                if (v_reg[0])
                begin
                    lvl2_reg[i] <= acc;
                end
            end
        end

        for (i = 0; i < L3; i++)
        begin : g_l3
            logic [VAL_W-1:0] acc;
            always_comb
            begin
                acc = '0;
                for (int j = 0; j < GROUP; j++)
                begin
                    acc = acc | p2[i*GROUP + j];
                end
            end
            always_ff @(posedge clk)
            begin
                if (v_reg[1])
                begin
                    lvl3_reg[i] <= acc;
                end
            end
        end
    endgenerate

    always_comb
    begin
        value = '0;
        for (int j = 0; j < L3; j++)
        begin
            value = value | lvl3_reg[j];
        end
    end

    assign v_next = {v_reg[1:0], cap};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign valid = v_reg[2];

endmodule

`default_nettype wire

// File: src/rpd_checker.sv
`default_nettype none
`include "random_permutation_drawer_assert.svh"

module rpd_checker #(
    parameter int MAX_SIZE = 1024
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [$clog2(MAX_SIZE)-1:0] drawn_value,
    input wire logic                        last_draw
);

    logic                      req_acc;
    logic                      rsp_stall;
    logic [$clog2(MAX_SIZE):0] rsp_word;

    assign req_acc   = req_valid && req_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_word  = {drawn_value, last_draw};

    // a stalled result word holds
    `RPD_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "held result changed")

    // one draw in flight at a time
    `RPD_ASSERT_NXT(a_one_in_flight, req_acc, !req_ready, "input taken while a draw is running")

    // a draw cannot finish in the cycle after it starts
    `RPD_ASSERT_NXT(a_no_early_result, req_acc, !$rose(rsp_valid), "result appeared too early")

    `RPD_ASSERT_IMP(a_value_range, rsp_valid, 32'(drawn_value) < MAX_SIZE, "value out of range")

endmodule

bind random_permutation_drawer rpd_checker #(
    .MAX_SIZE (MAX_SIZE)
) u_rpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .drawn_value (rsp.drawn_value),
    .last_draw   (rsp.last_draw)
);

`default_nettype wire

// File: sim/random_permutation_drawer_tb.sv
`timescale 1ns / 1ps

module random_permutation_drawer_tb import rpd_pkg::*; ();

    localparam int POOL_DEPTH  = 1024;
    localparam int VALUE_W     = 10;
    localparam int DRAW_BUDGET = 1850;
    // Wait after the last result before touching registers, with margin.
    localparam int SETTLE_CYCLES = 45;
    localparam int N_DIRECTED    = 29;

    // Indexes past the end of the register list; writes there must be no-ops.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } draw_t;

    typedef enum bit {
        ROW_DRAW,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table. For register rows, word carries the data.
    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    word;
        bit                   typed;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } step_t;

    logic clk;
    logic rst_n;

    rpd_in_if                       req_if ();
    rpd_out_if #(.VAL_W(VALUE_W))   rsp_if ();
    rpd_cfg_if                      cfg_if ();

    random_permutation_drawer #(
        .MAX_SIZE (POOL_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // Shadow of the drawer: value list, draw progress and both registers.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] unused_values [POOL_DEPTH];
    logic [CFG_W-1:0]   draws_taken;
    logic [CFG_W-1:0]   size_reg;
    logic [CFG_W-1:0]   count_reg;

    // Draws accepted on req whose result word has not come back yet.
    draw_t pending_draws [$];

    int error_count;
    int draws_sent;

    function automatic void refill_values();
        for (int k = 0; k < POOL_DEPTH; k++)
            unused_values[k] = VALUE_W'(k);
        draws_taken = '0;
    endfunction

    // Size register saturates at the list depth; zero acts as one.
    function automatic int unsigned live_size();
        int unsigned s;
        s = size_reg;
        if (s > POOL_DEPTH)
            s = POOL_DEPTH;
        if (s == 0)
            s = 1;
        return s;
    endfunction

    // Count saturates at the live size; zero acts as one.
    function automatic int unsigned live_count();
        int unsigned c;
        c = count_reg;
        if (c > live_size())
            c = live_size();
        if (c == 0)
            c = 1;
        return c;
    endfunction

    // Values still in the list for the next draw.
    function automatic int unsigned values_left();
        if (draws_taken >= live_count())
            return live_size();
        return live_size() - draws_taken;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == REG_SIZE)
            size_reg = data;
        else if (idx == REG_COUNT)
            count_reg = data;
        else
            return;     // unknown index leaves list and progress alone
        refill_values();
    endfunction

    // Draw one value: position is the word modulo what is left, then the
    // tail of the list slides down over the hole.
    function automatic draw_t draw_value(logic [WORD_W-1:0] word);
        draw_t       d;
        int unsigned left;
        int unsigned pos;
        if (draws_taken >= live_count())
            refill_values();
        left    = live_size() - draws_taken;
        pos     = word % left;
        d.value = unused_values[pos];
        for (int unsigned j = pos + 1; j < left; j++)
            unused_values[j - 1] = unused_values[j];
        draws_taken = draws_taken + 1'b1;
        d.last      = (draws_taken >= live_count());
        if (d.last)
            refill_values();
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Random shaping helpers.
    // ------------------------------------------------------------------

    // Sender gap: none when steady, else mostly back to back, some short pauses, a few long ones.
    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Full-range words cover every bit; small and near-max words aim at the
    // ends of the list and at the wrap of the remainder.
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        int unsigned left;
        left = values_left();
        r    = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 8)
            return $urandom_range(0, 2 * left - 1);
        return 32'hFFFF_FFFF - $urandom_range(0, 2 * left);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge, handshakes are seen on the
    // rising edge.
    // ------------------------------------------------------------------

    // Present one random word. valid stays high after acceptance so that a
    // back-to-back word follows at the next falling edge without valid dropping.
    task automatic send_draw(input logic [WORD_W-1:0] word, input int unsigned gap,
                             input bit typed, input logic [VALUE_W-1:0] tv,
                             input logic tl);
        draw_t d;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.random_word <= word;
        do
            @(posedge clk);
        while (!req_if.ready);
        d = draw_value(word);
        if (typed)
        begin
            d.value = tv;
            d.last  = tl;
        end
        pending_draws.push_back(d);
        draws_sent++;
    endtask

    // Register write: drop req, drain every result, let the block settle,
    // then one word on the config channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        apply_write(idx, data);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table: reset contents, size and count extremes, writes to
    // unknown indexes mid-permutation, and a rewrite that restarts a
    // permutation. Rows marked typed carry their result; the rest go
    // through the shadow model.
    // ------------------------------------------------------------------
    step_t directed_steps [N_DIRECTED] = '{
        // identity after reset, default size and count
        '{ROW_DRAW, '0,               32'd0,          1'b1, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'hFFFF_FFFF,  1'b0, 10'd0,    1'b0},
        // single-value list: count saturates to one, every draw is last
        '{ROW_CFG,  REG_SIZE,         32'd1,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'hFFFF_FFFF,  1'b1, 10'd0,    1'b1},
        '{ROW_DRAW, '0,               32'd12345,      1'b1, 10'd0,    1'b1},
        // size zero behaves as one
        '{ROW_CFG,  REG_SIZE,         32'd0,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd7,          1'b1, 10'd0,    1'b1},
        // size above the list depth saturates, count zero behaves as one
        '{ROW_CFG,  REG_SIZE,         32'd2047,       1'b0, 10'd0,    1'b0},
        '{ROW_CFG,  REG_COUNT,        32'd0,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd1023,       1'b1, 10'd1023, 1'b1},
        '{ROW_DRAW, '0,               32'd1024,       1'b1, 10'd0,    1'b1},
        '{ROW_DRAW, '0,               32'hFFFF_FFFF,  1'b1, 10'd1023, 1'b1},
        // unknown indexes between two draws must not restart the list
        '{ROW_CFG,  REG_COUNT,        32'd2,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd5,          1'b1, 10'd5,    1'b0},
        '{ROW_CFG,  REG_FIRST_UNUSED, 32'd0,          1'b0, 10'd0,    1'b0},
        '{ROW_CFG,  REG_LAST_UNUSED,  32'h7FF,        1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd5,          1'b1, 10'd6,    1'b1},
        // a register write mid-permutation starts over
        '{ROW_CFG,  REG_COUNT,        32'd3,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd0,          1'b1, 10'd0,    1'b0},
        '{ROW_CFG,  REG_COUNT,        32'd3,          1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd0,          1'b1, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd0,          1'b1, 10'd1,    1'b0},
        '{ROW_DRAW, '0,               32'd0,          1'b1, 10'd2,    1'b1},
        // count far above size saturates at size
        '{ROW_CFG,  REG_SIZE,         32'd2,          1'b0, 10'd0,    1'b0},
        '{ROW_CFG,  REG_COUNT,        32'd2047,       1'b0, 10'd0,    1'b0},
        '{ROW_DRAW, '0,               32'd1,          1'b1, 10'd1,    1'b0},
        '{ROW_DRAW, '0,               32'hFFFF_FFFF,  1'b1, 10'd0,    1'b1},
        // back to the reset setting
        '{ROW_CFG,  REG_SIZE,         32'd1024,       1'b0, 10'd0,    1'b0},
        '{ROW_CFG,  REG_COUNT,        32'd1024,       1'b0, 10'd0,    1'b0}
    };

    // ------------------------------------------------------------------
    // Clock and the run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Slowest sane run is well under 5 ms; anything past this is a hang.
    initial
    begin
        #25_000_000;
        $display("random_permutation_drawer_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls with occasional long holds and
    // stretches of steady ready.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        int unsigned r;
        bit          on;
        hold = 0;
        on   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 15);
                if (r == 0)
                begin
                    on   = 1'b1;
                    hold = $urandom_range(100, 300);
                end
                else if (r == 1)
                begin
                    on   = 1'b0;
                    hold = $urandom_range(20, 80);
                end
                else
                begin
                    on   = ($urandom_range(0, 3) != 0);
                    hold = $urandom_range(0, 3);
                end
                rsp_if.ready <= on;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest
    // outstanding draw.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("result word with no draw outstanding: drawn_value %0d last_draw %0b",
                       rsp_if.drawn_value, rsp_if.last_draw);
                error_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (rsp_if.drawn_value !== want.value)
                begin
                    $error("drawn_value: expected %0d, got %0d", want.value, rsp_if.drawn_value);
                    error_count++;
                end
                if (rsp_if.last_draw !== want.last)
                begin
                    $error("last_draw: expected %0b, got %0b", want.last, rsp_if.last_draw);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned size_v;
        int unsigned count_v;
        int unsigned n;
        int unsigned r;
        int          bad_at;
        bit          steady;
        bit          full_done;
        bit          full;

        // Everything known from time zero; reset is held low, then released on a falling edge.
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.random_word = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.idx         = '0;
        cfg_if.data        = '0;
        error_count        = 0;
        draws_sent         = 0;
        full_done          = 1'b0;

        size_reg  = RST_SIZE;
        count_reg = RST_COUNT;
        refill_values();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_steps[i].kind == ROW_CFG)
                write_reg(directed_steps[i].idx, directed_steps[i].word[CFG_W-1:0]);
            else
                send_draw(directed_steps[i].word, pick_gap(1'b0), directed_steps[i].typed,
                          directed_steps[i].value, directed_steps[i].last);
        end

        // Random phases: a fresh setting each time, then mostly whole
        // permutations (several in a row) with random words. One phase runs
        // a near-full list to the end so the deep tail gets exercised.
        while (draws_sent < DRAW_BUDGET)
        begin
            full = 1'b0;
            r    = $urandom_range(0, 9);
            if (r < 6)
                size_v = $urandom_range(1, 16);
            else if (r < 8)
                size_v = $urandom_range(17, 300);
            else if (r == 8)
            begin
                case ($urandom_range(0, 5))
                    0:       size_v = 0;
                    1:       size_v = 1;
                    2:       size_v = 2;
                    3:       size_v = 1024;
                    4:       size_v = 1025;
                    default: size_v = 2047;
                endcase
            end
            else
                size_v = $urandom_range(300, 1024);

            r = $urandom_range(0, 9);
            if (r < 6)
                count_v = $urandom_range(1, (size_v == 0) ? 1 : size_v);
            else if (r == 6)
                count_v = size_v;
            else if (r == 7)
                count_v = 0;
            else if (r == 8)
                count_v = $urandom_range(size_v + 1, 2047);
            else
                count_v = $urandom_range(0, 2047);

            if (!full_done && draws_sent > 300)
            begin
                size_v    = $urandom_range(1000, 1024);
                count_v   = 2047;
                full      = 1'b1;
                full_done = 1'b1;
            end

            // Either order; both registers land on every phase.
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_SIZE, CFG_W'(size_v));
                write_reg(REG_COUNT, CFG_W'(count_v));
            end
            else
            begin
                write_reg(REG_COUNT, CFG_W'(count_v));
                write_reg(REG_SIZE, CFG_W'(size_v));
            end

            if (full)
                n = live_size();
            else
            begin
                n = live_count() * $urandom_range(1, 3) + $urandom_range(0, live_count());
                if (n > 250)
                    n = 250;
                if (n > DRAW_BUDGET - draws_sent)
                    n = DRAW_BUDGET - draws_sent;
                if (n == 0)
                    n = 1;
            end

            steady = ($urandom_range(0, 3) == 0);
            bad_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n - 1)) : -1;

            for (int k = 0; k < n; k++)
            begin
                // unknown index in the middle of a permutation
                if (k == bad_at)
                    write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom));
                send_draw(pick_word(), pick_gap(steady), 1'b0, '0, 1'b0);
            end
        end

        // Drain: stop sending, wait for every result, then the settling wait used before
        // register writes, to catch stray result words.
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("random_permutation_drawer_tb: clean");
        else
            $display("random_permutation_drawer_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/rpd_pkg.sv
src/rpd_channels.sv
src/rpd_cell.sv
src/rpd_mod_unit.sv
src/rpd_collect.sv
src/random_permutation_drawer.sv
src/rpd_checker.sv
sim/random_permutation_drawer_tb.sv
